// ----- src/wfsv_pkg.sv -----
package wfsv_pkg;

  // Field and register widths.
  localparam int KIND_W    = 2;
  localparam int NOTE_W    = 7;
  localparam int DELAY_W   = 16;
  localparam int AMOUNT_W  = 16;
  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 17;
  localparam int CFG_W     = 17;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int ROM_W     = 18;
  localparam int K_W       = 22;
  localparam int AX_W      = 22;
  localparam int PHASE_W   = 32;

  // Shared serial multiplier operand widths.
  localparam int MUL_AW = 44;
  localparam int MUL_BW = 22;

  // Default parameter values.
  localparam int DEF_SAMPLE_RATE      = 48000;
  localparam int DEF_SINE_TABLE_DEPTH = 1024;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ON   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OFF  = 2'd2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_GAIN_ATTACK    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_DECAY     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_SUSTAIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_RELEASE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TIMBRE_ATTACK  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TIMBRE_DECAY   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TIMBRE_SUSTAIN = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TIMBRE_RELEASE = 3'd7;

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
    17'd64, 17'd64, 17'd49152, 17'd16, 17'd64, 17'd64, 17'd32768, 17'd16
  };

  // Fixed-point constants.
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 17'd65536;
  localparam logic [LEVEL_W-1:0] DEAD_LIMIT = 17'd7;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [29:0] FOLD_C1_Q32 = 30'd615208749;
  localparam logic [17:0] FOLD_C2_Q24 = 18'd133509;

  localparam logic [63:0] TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  localparam logic [63:0] BASE_FREQ_Q16 [12] = '{
    64'd535809, 64'd567670, 64'd601425, 64'd637188, 64'd675077, 64'd715219,
    64'd757749, 64'd802807, 64'd850544, 64'd901120, 64'd954703, 64'd1011473
  };

  typedef enum logic [1:0] {
    ENV_ATTACK  = 2'd0,
    ENV_DECAY   = 2'd1,
    ENV_SUSTAIN = 2'd2,
    ENV_RELEASE = 2'd3
  } env_stage_t;

  typedef struct packed {
    logic [CFG_W-1:0] attack;
    logic [CFG_W-1:0] decay;
    logic [CFG_W-1:0] sustain;
    logic [CFG_W-1:0] release_step;
  } env_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADDR1,
    S_MUL_K,
    S_MUL_X,
    S_MUL_T1,
    S_MUL_SQ,
    S_MUL_T2,
    S_ADDR2,
    S_READ2,
    S_GAIN,
    S_MUL_G,
    S_DONE
  } seq_state_t;

endpackage

// ----- src/wfsv_if.sv -----
interface wfsv_in_if import wfsv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [NOTE_W-1:0]   note_number;
  logic [DELAY_W-1:0]  sample_delay;
  logic [AMOUNT_W-1:0] timbre_amount;

  modport source (output valid, kind, note_number, sample_delay, timbre_amount,
                  input ready);
  modport sink (input valid, kind, note_number, sample_delay, timbre_amount,
                output ready);
endinterface

interface wfsv_out_if import wfsv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       voice_dead;
  logic [NOTE_W-1:0]          held_note;

  modport source (output valid, sample, voice_dead, held_note, input ready);
  modport sink (input valid, sample, voice_dead, held_note, output ready);
endinterface

// ----- src/wavefold_synth_voice_top.sv -----
// Note on, note off, unused kinds and ticks inside the start delay go straight
// to the done state, which loads the result into the output register. An
// audible tick makes six passes through the one bit-serial multiplier plus
// table addressing, then the output load. No new item is taken before the load,
// and a stalled output register holds off the next item. Synchronous
// active-high reset restores voice state and register defaults.
module wavefold_synth_voice_top import wfsv_pkg::*; #(
  parameter int SAMPLE_RATE      = DEF_SAMPLE_RATE,
  parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  wfsv_in_if.sink              in_ch,
  wfsv_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW      = MUL_AW + MUL_BW;

  // Phase increment per note: round(f * 2^(note/12 + 16) / SAMPLE_RATE).
  typedef logic [PHASE_W-1:0] inc_tab_t [128];

  function automatic inc_tab_t build_inc();
    inc_tab_t    t;
    logic [63:0] num;
    for (int n = 0; n < 128; n++) begin
      num  = BASE_FREQ_Q16[n % 12] << (n / 12 + 16);
      t[n] = PHASE_W'((num + 64'(SAMPLE_RATE / 2)) / SAMPLE_RATE);
    end
    return t;
  endfunction

  localparam inc_tab_t INC_TAB = build_inc();

  // Configuration registers and voice state.
  logic [CFG_W-1:0]    cfg_regs [NUM_REGS];
  logic [PHASE_W-1:0]  phase_acc;
  logic                note_held;
  logic [DELAY_W-1:0]  start_countdown;
  logic                off_pending;
  logic [DELAY_W-1:0]  off_countdown;
  logic [NOTE_W-1:0]   note_reg;
  logic [AMOUNT_W-1:0] amount_reg;

  // Working registers of one audible tick.
  seq_state_t          state;
  seq_state_t          state_next;
  logic [IDX_W-1:0]    idx;
  logic                x_neg;
  logic                f_neg;
  logic [AX_W-1:0]     ax;
  logic [PHASE_W-1:0]  t1;
  logic [PHASE_W-1:0]  turn;
  logic [SAMPLE_W-1:0] res_sample;

  logic                accept;
  logic                tick_live;
  logic                held_next;
  logic                out_load;
  logic                note_on;
  logic [LEVEL_W-1:0]  gain_level;
  logic [LEVEL_W-1:0]  timbre_level;
  env_cfg_t            gain_cfg;
  env_cfg_t            timbre_cfg;

  logic                mul_start;
  logic [MUL_AW-1:0]   mul_a;
  logic [MUL_BW-1:0]   mul_b;
  logic                mul_done;
  logic [PW-1:0]       product;

  logic signed [ROM_W-1:0] rom_data;
  logic [LEVEL_W-1:0]      rom_mag;
  logic [PHASE_W-1:0]      idx_src;
  logic [PHASE_W+DEPTH_W-1:0] idx_prod;

  logic [36:0]         amt15;
  logic [K_W-1:0]      k_val;
  logic [39:0]         ax_sum;
  logic [47:0]         t1_sum;
  logic [55:0]         t2_sum;
  logic [PHASE_W-1:0]  t2_val;
  logic [34:0]         g_sum;
  logic [17:0]         g_mag;
  logic [SAMPLE_W-1:0] sat_val;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign note_on     = accept && (in_ch.kind == KIND_ON);
  // An audible tick: a tick once the start delay has run out.
  assign tick_live   = accept && (in_ch.kind == KIND_TICK) && (start_countdown == '0);
  // The pending note off ends the hold on the tick where its countdown expires.
  assign held_next   = (tick_live && off_pending && (off_countdown <= DELAY_W'(1)))
                       ? 1'b0 : note_held;
  assign out_load    = (state == S_DONE) && (!out_ch.valid || out_ch.ready);

  assign gain_cfg   = '{attack:       cfg_regs[REG_GAIN_ATTACK],
                        decay:        cfg_regs[REG_GAIN_DECAY],
                        sustain:      cfg_regs[REG_GAIN_SUSTAIN],
                        release_step: cfg_regs[REG_GAIN_RELEASE]};
  assign timbre_cfg = '{attack:       cfg_regs[REG_TIMBRE_ATTACK],
                        decay:        cfg_regs[REG_TIMBRE_DECAY],
                        sustain:      cfg_regs[REG_TIMBRE_SUSTAIN],
                        release_step: cfg_regs[REG_TIMBRE_RELEASE]};

  wfsv_env u_gain_env (
    .clk     (clk),
    .rst     (rst),
    .cfg     (gain_cfg),
    .note_on (note_on),
    .step_en (tick_live),
    .held    (held_next),
    .level   (gain_level)
  );

  wfsv_env u_timbre_env (
    .clk     (clk),
    .rst     (rst),
    .cfg     (timbre_cfg),
    .note_on (note_on),
    .step_en (tick_live),
    .held    (held_next),
    .level   (timbre_level)
  );

  wfsv_serial_mul #(
    .AW (MUL_AW),
    .BW (MUL_BW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (product)
  );

  wfsv_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (idx),
    .data (rom_data)
  );

  // Table index is the top bits of turn * depth. The first lookup uses the
  // oscillator phase, the second the fold angle.
  assign idx_src  = (state == S_ADDR1) ? phase_acc : turn;
  assign idx_prod = {{DEPTH_W{1'b0}}, idx_src} * DEPTH_W'(SINE_TABLE_DEPTH);
  assign rom_mag  = rom_data[ROM_W-1] ? LEVEL_W'(-rom_data) : rom_data[LEVEL_W-1:0];

  // Fold depth k = 1.0 + 15 * amount * timbre, all in Q16.
  assign amt15  = {product[32:0], 4'b0000} - {4'b0000, product[32:0]};
  assign k_val  = K_W'(FULL_SCALE) + K_W'(amt15[36:16]);
  // |x| = round(k * |sin| / 2^16).
  assign ax_sum = {1'b0, product[38:0]} + 40'd32768;
  // Linear and square terms of the fold angle, kept modulo one turn.
  assign t1_sum = product[47:0] + 48'd32768;
  assign t2_sum = product[55:0] + 56'd8388608;
  assign t2_val = t2_sum[55:24];
  // Output magnitude round(gain * |f| / 2^17), then saturate with the sign.
  assign g_sum  = {1'b0, product[33:0]} + 35'd65536;
  assign g_mag  = g_sum[34:17];

  always_comb begin
    if (f_neg) begin
      sat_val = (g_mag > 18'd32768) ? 16'h8000 : SAMPLE_W'(-g_mag);
    end else begin
      sat_val = (g_mag > 18'd32767) ? 16'h7FFF : g_mag[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: the X, T1, SQ and T2 passes launch as the previous pass ends.
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = tick_live ? S_ADDR1 : S_DONE;
        end
      end
      S_ADDR1: begin
        mul_start  = 1'b1;
        mul_a      = MUL_AW'(timbre_level);
        mul_b      = MUL_BW'(amount_reg);
        state_next = S_MUL_K;
      end
      S_MUL_K: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = MUL_AW'(k_val);
          mul_b      = MUL_BW'(rom_mag);
          state_next = S_MUL_X;
        end
      end
      S_MUL_X: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = MUL_AW'(FOLD_C1_Q32);
          mul_b      = ax_sum[16 +: AX_W];
          state_next = S_MUL_T1;
        end
      end
      S_MUL_T1: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = MUL_AW'(ax);
          mul_b      = ax;
          state_next = S_MUL_SQ;
        end
      end
      S_MUL_SQ: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = product[MUL_AW-1:0];
          mul_b      = MUL_BW'(FOLD_C2_Q24);
          state_next = S_MUL_T2;
        end
      end
      S_MUL_T2: begin
        if (mul_done) begin
          state_next = S_ADDR2;
        end
      end
      S_ADDR2: begin
        state_next = S_READ2;
      end
      S_READ2: begin
        state_next = S_GAIN;
      end
      S_GAIN: begin
        mul_start  = 1'b1;
        mul_a      = MUL_AW'(gain_level);
        mul_b      = MUL_BW'(rom_mag);
        state_next = S_MUL_G;
      end
      S_MUL_G: begin
        if (mul_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Voice state, configuration and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_regs[i] <= CFG_RESET[i];
      end
      phase_acc       <= '0;
      note_held       <= 1'b0;
      start_countdown <= '0;
      off_pending     <= 1'b0;
      off_countdown   <= '0;
      note_reg        <= '0;
      amount_reg      <= '0;
      out_ch.valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_regs[cfg_index] <= cfg_data;
      end
      if (accept) begin
        unique case (in_ch.kind)
          KIND_ON: begin
            note_reg        <= in_ch.note_number;
            amount_reg      <= in_ch.timbre_amount;
            start_countdown <= in_ch.sample_delay;
            note_held       <= 1'b1;
            off_pending     <= 1'b0;
            off_countdown   <= '0;
          end
          KIND_OFF: begin
            off_pending   <= 1'b1;
            off_countdown <= in_ch.sample_delay;
          end
          KIND_TICK: begin
            if (start_countdown != '0) begin
              start_countdown <= start_countdown - DELAY_W'(1);
            end else begin
              if (off_pending) begin
                if (off_countdown <= DELAY_W'(1)) begin
                  off_pending   <= 1'b0;
                  off_countdown <= '0;
                end else begin
                  off_countdown <= off_countdown - DELAY_W'(1);
                end
              end
              note_held <= held_next;
              phase_acc <= phase_acc + INC_TAB[note_reg];
            end
          end
          default: begin
            note_held <= note_held;
          end
        endcase
      end
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // Datapath registers of the tick sequence and the output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_sample <= '0;
    end
    if (state == S_ADDR1 || state == S_ADDR2) begin
      idx <= idx_prod[PHASE_W +: IDX_W];
    end
    if (state == S_MUL_K && mul_done) begin
      x_neg <= rom_data[ROM_W-1];
    end
    if (state == S_MUL_X && mul_done) begin
      ax <= ax_sum[16 +: AX_W];
    end
    if (state == S_MUL_T1 && mul_done) begin
      t1 <= t1_sum[47:16];
    end
    if (state == S_MUL_T2 && mul_done) begin
      turn <= x_neg ? t2_val - t1 : t2_val + t1;
    end
    if (state == S_GAIN) begin
      f_neg <= rom_data[ROM_W-1];
    end
    if (state == S_MUL_G && mul_done) begin
      res_sample <= sat_val;
    end
    if (out_load) begin
      out_ch.sample     <= res_sample;
      out_ch.voice_dead <= (gain_level < DEAD_LIMIT) && !note_held;
      out_ch.held_note  <= note_reg;
    end
  end

endmodule

// ----- src/wfsv_serial_mul.sv -----
module wfsv_serial_mul import wfsv_pkg::*; #(
  parameter int AW = MUL_AW,
  parameter int BW = MUL_BW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] product
);

  localparam int CW = $clog2(BW + 1);

  // Shift-add multiplier: one multiplier bit per cycle, partial sum shifts right.
  logic [AW+BW:0] acc;
  logic [AW-1:0]  mcand;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [AW+1:0]  sum;

  assign sum = {1'b0, acc[AW+BW:BW]} + {2'b00, (acc[0] ? mcand : AW'(0))};
  assign product = acc[AW+BW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= {(AW + 1)'(0), b};
      mcand <= a;
    end else if (busy) begin
      acc <= {sum, acc[BW-1:1]};
    end
  end

endmodule

// ----- src/wfsv_sine_rom.sv -----
module wfsv_sine_rom import wfsv_pkg::*; #(
  parameter int DEPTH = DEF_SINE_TABLE_DEPTH
) (
  input  logic                    clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output logic signed [ROM_W-1:0] data
);

  typedef logic signed [ROM_W-1:0] sine_tab_t [DEPTH];

  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
      if ((k % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  function automatic sine_tab_t build_tab();
    sine_tab_t   t;
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] q16;
    for (int i = 0; i < DEPTH; i++) begin
      u = (64'(i) << 32) / DEPTH;
      r = {34'd0, u[29:0]};
      if (u[30]) begin
        r = 64'h4000_0000 - r;
      end
      s   = sin_q30((r * HALF_PI_Q30) >> 30);
      q16 = (s + 64'd8192) >> 14;
      if (q16 > 64'd65536) begin
        q16 = 64'd65536;
      end
      t[i] = u[31] ? -ROM_W'(q16) : ROM_W'(q16);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_tab();

  always_ff @(posedge clk) begin
    data <= SINE_TAB[addr];
  end

endmodule

// ----- src/wfsv_env.sv -----
module wfsv_env import wfsv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  env_cfg_t           cfg,
  input  logic               note_on,
  input  logic               step_en,
  input  logic               held,
  output logic [LEVEL_W-1:0] level
);

  env_stage_t         stage;
  env_stage_t         stage_eff;
  env_stage_t         stage_next;
  logic [LEVEL_W-1:0] level_next;
  logic [LEVEL_W:0]   rise;
  logic [LEVEL_W-1:0] fall_d;
  logic [LEVEL_W-1:0] fall_r;

  assign rise   = {1'b0, level} + {1'b0, cfg.attack};
  assign fall_d = (level > cfg.decay) ? level - cfg.decay : '0;
  assign fall_r = (level > cfg.release_step) ? level - cfg.release_step : '0;

  // A released note always steps in release.
  always_comb begin
    stage_eff  = held ? stage : ENV_RELEASE;
    stage_next = stage_eff;
    level_next = level;
    unique case (stage_eff)
      ENV_ATTACK: begin
        if (rise >= {1'b0, FULL_SCALE}) begin
          level_next = FULL_SCALE;
          stage_next = ENV_DECAY;
        end else begin
          level_next = rise[LEVEL_W-1:0];
        end
      end
      ENV_DECAY: begin
        if (fall_d <= cfg.sustain) begin
          level_next = cfg.sustain;
          stage_next = ENV_SUSTAIN;
        end else begin
          level_next = fall_d;
        end
      end
      ENV_SUSTAIN: begin
        level_next = level;
      end
      ENV_RELEASE: begin
        level_next = fall_r;
      end
      default: begin
        level_next = level;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      stage <= ENV_RELEASE;
    end else if (note_on) begin
      stage <= ENV_ATTACK;
    end else if (step_en) begin
      level <= level_next;
      stage <= stage_next;
    end
  end

endmodule
